// ----- rtl/core/lras_pkg.sv -----
// Shared types and constants for the lazy range-add / range-sum tree.
// Used by the controller, the datapath and the top level; depends on nothing.
package lras_pkg;

  localparam int INDEX_W = 10;
  localparam int VALUE_W = 32;
  localparam int SUM_W   = 64;

  typedef enum logic [1:0] {
    KIND_SET   = 2'd0,
    KIND_BUILD = 2'd1,
    KIND_ADD   = 2'd2,
    KIND_QUERY = 2'd3
  } kind_t;

  // Memory address sources
  typedef enum logic [2:0] {
    A_NODE,
    A_LCH,
    A_RCH,
    A_SWP,
    A_LEAF
  } addr_sel_t;

  typedef enum logic [1:0] {
    SD_ZERO,
    SD_AMOUNT,
    SD_TRUE,
    SD_PAIR
  } sum_wd_t;

  typedef enum logic [1:0] {
    PD_ZERO,
    PD_AMOUNT,
    PD_CARRY
  } pend_wd_t;

  typedef enum logic [2:0] {
    NODE_HOLD,
    NODE_ROOT,
    NODE_DOWN,
    NODE_SIBLING,
    NODE_UP,
    NODE_BUILD,
    NODE_DEC
  } node_op_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_ERR,
    RES_SUM
  } res_op_t;

  typedef struct packed {
    logic      load_item;
    logic      sweep_init;
    logic      sweep_inc;
    node_op_t  node_op;
    logic      sum_rd;
    addr_sel_t sum_ra;
    logic      pend_rd;
    addr_sel_t pend_ra;
    logic      sum_wr;
    addr_sel_t sum_wa;
    sum_wd_t   sum_wd;
    logic      pend_wr;
    addr_sel_t pend_wa;
    pend_wd_t  pend_wd;
    logic      shift_child;
    logic      load_t;
    logic      load_u;
    logic      load_p;
    logic      acc_clr;
    logic      acc_add;
    res_op_t   res_op;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  reversed;
    logic  covered;
    logic  disjoint;
    logic  leaf;
    logic  root;
    logic  right_child;
    logic  sweep_last;
  } dp_status_t;

endpackage

// ----- rtl/core/lazy_range_add_sum_tree.sv -----
// Lazy segment tree, range add and range sum over LEAVES 64-bit leaves.
// Set writes one leaf; build clears pending adds, then sums each inner node
// from its children; add and query walk node by node, paced by the single
// read and write port of each node memory. One item at a time; busy is high.
// Reset: synchronous; a clearing pass zeroes both memories, busy high
// throughout. Results strobe for one cycle; the receiver cannot stall.
module lazy_range_add_sum_tree
  import lras_pkg::*;
#(
  parameter int LEAVES = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                kind,
  input  logic [INDEX_W-1:0]        left_index,
  input  logic [INDEX_W-1:0]        right_index,
  input  logic signed [VALUE_W-1:0] operand_value,
  output logic                      result_valid,
  output logic signed [SUM_W-1:0]   range_sum,
  output logic                      range_error
);

  // Command and status between the sequencer and the datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer: a transfer is taken when start is high and busy is low
  lras_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  // Memories and walk registers; the walk climbs by halving the node index,
  // so no return stack is needed
  lras_datapath #(
    .LEAVES (LEAVES)
  ) u_dp (
    .clk           (clk),
    .kind          (kind),
    .left_index    (left_index),
    .right_index   (right_index),
    .operand_value (operand_value),
    .cmd           (cmd),
    .status        (status),
    .range_sum     (range_sum),
    .range_error   (range_error)
  );

endmodule

// ----- rtl/core/lras_datapath.sv -----
// Datapath: node sum and pending-add memories, walk registers, accumulator.
// Depends on lras_pkg; driven by lras_controller through dp_cmd_t.
module lras_datapath
  import lras_pkg::*;
#(
  parameter int LEAVES = 1024
) (
  input  logic                      clk,
  input  logic [1:0]                kind,
  input  logic [INDEX_W-1:0]        left_index,
  input  logic [INDEX_W-1:0]        right_index,
  input  logic signed [VALUE_W-1:0] operand_value,
  input  dp_cmd_t                   cmd,
  output dp_status_t                status,
  output logic signed [SUM_W-1:0]   range_sum,
  output logic                      range_error
);

  localparam int LOG   = $clog2(LEAVES);
  localparam int NW    = LOG + 1;
  localparam int HW    = $clog2(LOG + 1);
  localparam int NODES = 2 * LEAVES;

  logic [SUM_W-1:0] sum_mem  [NODES];
  logic [SUM_W-1:0] pend_mem [NODES];

  kind_t            kind_q;
  logic [LOG-1:0]   left_q;
  logic [LOG-1:0]   right_q;
  logic [SUM_W-1:0] amount;
  logic [NW-1:0]    node;
  logic [HW-1:0]    h;
  logic [NW-1:0]    sweep;
  logic [SUM_W-1:0] rd_sum;
  logic [SUM_W-1:0] rd_pend;
  logic [SUM_W-1:0] t;
  logic [SUM_W-1:0] u;
  logic [SUM_W-1:0] p;
  logic [SUM_W-1:0] acc;

  logic [HW-1:0]    shamt;
  logic [SUM_W-1:0] tru;
  logic [NW-1:0]    shifted;
  logic [NW-1:0]    mask_w;
  logic [LOG-1:0]   nl;
  logic [LOG-1:0]   nr;
  logic [SUM_W-1:0] sum_wd;
  logic [SUM_W-1:0] pend_wd;

  function automatic logic [NW-1:0] addr_of(addr_sel_t s, logic [NW-1:0] n,
                                            logic [NW-1:0] sw, logic [LOG-1:0] lf);
    logic [NW-1:0] a;
    case (s)
      A_NODE:  a = n;
      A_LCH:   a = {n[NW-2:0], 1'b0};
      A_RCH:   a = {n[NW-2:0], 1'b1};
      A_SWP:   a = sw;
      A_LEAF:  a = {1'b1, lf};
      default: a = n;
    endcase
    return a;
  endfunction

  // node range from its index and height
  assign shifted = node << h;
  assign mask_w  = (NW'(1) << h) - NW'(1);
  assign nl      = shifted[LOG-1:0];
  assign nr      = nl | mask_w[LOG-1:0];

  assign shamt = cmd.shift_child ? (h - HW'(1)) : h;
  assign tru   = rd_sum + (rd_pend << shamt);

  always_comb begin
    case (cmd.sum_wd)
      SD_ZERO:   sum_wd = '0;
      SD_AMOUNT: sum_wd = amount;
      SD_TRUE:   sum_wd = tru;
      SD_PAIR:   sum_wd = t + u;
      default:   sum_wd = '0;
    endcase
    case (cmd.pend_wd)
      PD_ZERO:   pend_wd = '0;
      PD_AMOUNT: pend_wd = rd_pend + amount;
      PD_CARRY:  pend_wd = rd_pend + p;
      default:   pend_wd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_wr) sum_mem[addr_of(cmd.sum_wa, node, sweep, left_q)] <= sum_wd;
    if (cmd.sum_rd) rd_sum <= sum_mem[addr_of(cmd.sum_ra, node, sweep, left_q)];
    if (cmd.pend_wr) pend_mem[addr_of(cmd.pend_wa, node, sweep, left_q)] <= pend_wd;
    if (cmd.pend_rd) rd_pend <= pend_mem[addr_of(cmd.pend_ra, node, sweep, left_q)];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_q  <= kind_t'(kind);
      left_q  <= LOG'(left_index);
      right_q <= LOG'(right_index);
      amount  <= {{(SUM_W-VALUE_W){operand_value[VALUE_W-1]}}, operand_value};
    end
    if (cmd.sweep_init)     sweep <= '0;
    else if (cmd.sweep_inc) sweep <= sweep + NW'(1);
    case (cmd.node_op)
      NODE_ROOT: begin
        node <= NW'(1);
        h    <= HW'(LOG);
      end
      NODE_DOWN: begin
        node <= {node[NW-2:0], 1'b0};
        h    <= h - HW'(1);
      end
      NODE_SIBLING: node <= node + NW'(1);
      NODE_UP: begin
        node <= node >> 1;
        h    <= h + HW'(1);
      end
      NODE_BUILD: begin
        node <= NW'(LEAVES - 1);
        h    <= HW'(1);
      end
      NODE_DEC: node <= node - NW'(1);
      default: ;
    endcase
    if (cmd.load_t) t <= tru;
    if (cmd.load_u) u <= tru;
    if (cmd.load_p) p <= rd_pend;
    if (cmd.acc_clr)      acc <= '0;
    else if (cmd.acc_add) acc <= acc + t;
    case (cmd.res_op)
      RES_ERR: begin
        range_sum   <= '0;
        range_error <= 1'b1;
      end
      RES_SUM: begin
        range_sum   <= acc;
        range_error <= 1'b0;
      end
      default: ;
    endcase
  end

  assign status.kind        = kind_q;
  assign status.reversed    = left_q > right_q;
  assign status.covered     = (left_q <= nl) && (nr <= right_q);
  assign status.disjoint    = (nr < left_q) || (right_q < nl);
  assign status.leaf        = (h == '0);
  assign status.root        = (node == NW'(1));
  assign status.right_child = node[0];
  assign status.sweep_last  = (sweep == NW'(NODES - 1));

endmodule

// ----- rtl/core/lras_controller.sv -----
// Controller: sequences clearing sweeps, set, build, and the tree walk for add/query.
// Depends on lras_pkg; commands lras_datapath.
module lras_controller
  import lras_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       result_valid
);

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_DISPATCH,
    S_ENTER,
    S_ADDC,
    S_PB,
    S_PC,
    S_PD,
    S_PE,
    S_RET,
    S_PA,
    S_PB2,
    S_PC2,
    S_PD2
  } state_t;

  state_t state;
  state_t state_next;
  logic   clr_sum;
  logic   in_build;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_SWEEP: begin
        cmd.pend_wr   = 1'b1;
        cmd.pend_wa   = A_SWP;
        cmd.pend_wd   = PD_ZERO;
        cmd.sum_wr    = clr_sum;
        cmd.sum_wa    = A_SWP;
        cmd.sum_wd    = SD_ZERO;
        cmd.sweep_inc = 1'b1;
        if (status.sweep_last) begin
          if (in_build) begin
            cmd.node_op = NODE_BUILD;
            state_next  = S_PA;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status.kind)
          KIND_SET: begin
            cmd.sum_wr = 1'b1;
            cmd.sum_wa = A_LEAF;
            cmd.sum_wd = SD_AMOUNT;
            state_next = S_IDLE;
          end
          KIND_BUILD: begin
            cmd.sweep_init = 1'b1;
            state_next     = S_SWEEP;
          end
          default: begin
            if (status.reversed) begin
              cmd.res_op = RES_ERR;
              state_next = S_IDLE;
            end else begin
              cmd.node_op = NODE_ROOT;
              cmd.acc_clr = 1'b1;
              state_next  = S_ENTER;
            end
          end
        endcase
      end
      S_ENTER: begin
        if (status.disjoint) begin
          state_next = S_RET;
        end else if (status.kind == KIND_ADD && status.covered) begin
          cmd.pend_rd = 1'b1;
          cmd.pend_ra = A_NODE;
          state_next  = S_ADDC;
        end else begin
          cmd.sum_rd  = 1'b1;
          cmd.sum_ra  = A_NODE;
          cmd.pend_rd = 1'b1;
          cmd.pend_ra = A_NODE;
          state_next  = S_PB;
        end
      end
      S_ADDC: begin
        cmd.pend_wr = 1'b1;
        cmd.pend_wa = A_NODE;
        cmd.pend_wd = PD_AMOUNT;
        state_next  = S_RET;
      end
      S_PB: begin
        // fold the pending add into the node, hold it for the children
        cmd.sum_wr  = 1'b1;
        cmd.sum_wa  = A_NODE;
        cmd.sum_wd  = SD_TRUE;
        cmd.load_t  = 1'b1;
        cmd.load_p  = 1'b1;
        cmd.pend_wr = 1'b1;
        cmd.pend_wa = A_NODE;
        cmd.pend_wd = PD_ZERO;
        if (!status.leaf) begin
          cmd.pend_rd = 1'b1;
          cmd.pend_ra = A_LCH;
          state_next  = S_PC;
        end else begin
          state_next = S_PE;
        end
      end
      S_PC: begin
        cmd.pend_wr = 1'b1;
        cmd.pend_wa = A_LCH;
        cmd.pend_wd = PD_CARRY;
        cmd.pend_rd = 1'b1;
        cmd.pend_ra = A_RCH;
        state_next  = S_PD;
      end
      S_PD: begin
        cmd.pend_wr = 1'b1;
        cmd.pend_wa = A_RCH;
        cmd.pend_wd = PD_CARRY;
        state_next  = S_PE;
      end
      S_PE: begin
        if (status.covered) begin
          cmd.acc_add = 1'b1;
          state_next  = S_RET;
        end else begin
          cmd.node_op = NODE_DOWN;
          state_next  = S_ENTER;
        end
      end
      S_RET: begin
        if (status.root) begin
          if (status.kind == KIND_QUERY) cmd.res_op = RES_SUM;
          state_next = S_IDLE;
        end else if (!status.right_child) begin
          cmd.node_op = NODE_SIBLING;
          state_next  = S_ENTER;
        end else begin
          cmd.node_op = NODE_UP;
          state_next  = (status.kind == KIND_ADD) ? S_PA : S_RET;
        end
      end
      S_PA: begin
        cmd.sum_rd  = 1'b1;
        cmd.sum_ra  = A_LCH;
        cmd.pend_rd = 1'b1;
        cmd.pend_ra = A_LCH;
        state_next  = S_PB2;
      end
      S_PB2: begin
        cmd.shift_child = 1'b1;
        cmd.load_t      = 1'b1;
        cmd.sum_rd      = 1'b1;
        cmd.sum_ra      = A_RCH;
        cmd.pend_rd     = 1'b1;
        cmd.pend_ra     = A_RCH;
        state_next      = S_PC2;
      end
      S_PC2: begin
        cmd.shift_child = 1'b1;
        cmd.load_u      = 1'b1;
        state_next      = S_PD2;
      end
      S_PD2: begin
        cmd.sum_wr = 1'b1;
        cmd.sum_wa = A_NODE;
        cmd.sum_wd = SD_PAIR;
        if (in_build) begin
          if (status.root) begin
            state_next = S_IDLE;
          end else begin
            cmd.node_op = NODE_DEC;
            state_next  = S_PA;
          end
        end else begin
          state_next = S_RET;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // hold the sweep pointer at zero and drop all writes while in reset
    if (rst) begin
      cmd            = '0;
      cmd.sweep_init = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      clr_sum      <= 1'b1;
      in_build     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (cmd.res_op != RES_NONE);
      if (cmd.sweep_init) begin
        clr_sum  <= 1'b0;
        in_build <= 1'b1;
      end else if (state_next == S_IDLE) begin
        clr_sum  <= 1'b0;
        in_build <= 1'b0;
      end
    end
  end

endmodule
